// ===== sv/rfid_uid_read_sequencer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the card UID read sequencer
// Concurrent assertion wrappers, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef RFID_UID_READ_SEQUENCER_CORE_DEFINES_SVH
`define RFID_UID_READ_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RUS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RUS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RUS_ASSERT(label, clk, rst, prop, msg)
`define RUS_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

// ===== sv/rfid_pkg.sv =====
// ----------------------------------------------------------------------------
// rfid_pkg
// Shared types and codes of the card UID read sequencer.
// ----------------------------------------------------------------------------
package rfid_pkg;

  localparam int FIFO_READ_MAX = 16;
  localparam int UID_BYTES     = 5;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_REPLY = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_WRITE     = 2'd0,
    K_READ      = 2'd1,
    K_INIT_DONE = 2'd2,
    K_SCAN_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_SELECTED = 2'd0,
    ST_SEL_FAIL = 2'd1,
    ST_NO_CARD  = 2'd2,
    ST_UID_FAIL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_REQUEST  = 3'd0,
    CFG_POLL     = 3'd1,
    CFG_TMODE    = 3'd2,
    CFG_TPRESC   = 3'd3,
    CFG_TRELOAD  = 3'd4,
    CFG_MODE     = 3'd5,
    CFG_GAIN     = 3'd6,
    CFG_ERR_MASK = 3'd7
  } cfg_idx_t;

  // result sequence appended after the optional single accesses
  typedef enum logic [3:0] {
    T_NONE, T_INIT, T_INIT_DONE, T_SCAN, T_ANTI, T_SEL, T_HALT,
    T_SEL_FAIL, T_HALT_END, T_NO_CARD, T_UID_FAIL
  } tail_t;

  typedef struct packed {
    logic [7:0]  request_code;
    logic [6:0]  poll_limit;
    logic [7:0]  timer_mode;
    logic [7:0]  timer_prescaler;
    logic [15:0] timer_reload;
    logic [7:0]  mode_setting;
    logic [7:0]  rf_gain_setting;
    logic [7:0]  error_mask;
  } cfg_t;

  typedef struct packed {
    logic        pre_wr;
    logic [5:0]  pre_addr;
    logic [7:0]  pre_data;
    logic        pre_rd;
    logic [5:0]  rd_addr;
    tail_t       tail;
    logic [39:0] uid;
  } job_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  addr;
    logic [7:0]  data;
    status_t     status;
    logic [39:0] uid;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/rfid_front.sv =====
// ----------------------------------------------------------------------------
// rfid_front
// Accepts requests, steps the exchange state and issues jobs.
// ----------------------------------------------------------------------------
module rfid_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       operation,
  input  logic [7:0]       read_byte,
  input  rfid_pkg::cfg_t   cfg,
  output logic             job_valid,
  output rfid_pkg::job_t   job
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_INIT_TXC, PH_BF_SET, PH_WAIT_TICK, PH_WAIT_IRQ,
    PH_BF_CLEAR, PH_ERR, PH_LEVEL, PH_CTRL, PH_FIFO
  } phase_t;

  typedef enum logic [1:0] {XK_REQ, XK_ANTI, XK_SEL, XK_HALT} xkind_t;

  phase_t      phase, phase_next;
  xkind_t      xkind, xkind_next;
  logic [6:0]  polls_left, polls_left_next;
  logic [6:0]  fifo_level, fifo_level_next;
  logic [4:0]  read_index, read_index_next;
  logic [9:0]  received_bits, received_bits_next;
  logic [39:0] uid, uid_next;

  logic        do_end, end_ok, uid_good;
  logic [4:0]  read_count;
  logic [5:0]  ri_inc;
  logic [2:0]  lb;
  logic [7:0]  b;

  assign b      = read_byte;
  assign lb     = read_byte[2:0];
  assign ri_inc = {1'b0, read_index} + 6'd1;

  always_comb begin
    if (fifo_level == 7'd0) begin
      read_count = 5'd1;
    end else if (fifo_level > 7'(rfid_pkg::FIFO_READ_MAX)) begin
      read_count = 5'(rfid_pkg::FIFO_READ_MAX);
    end else begin
      read_count = fifo_level[4:0];
    end
  end

  assign uid_good = (uid_next[39:32] != 8'd0) &&
                    ((uid_next[39:32] ^ uid_next[31:24] ^ uid_next[23:16] ^
                      uid_next[15:8]) == uid_next[7:0]);

  always_comb begin
    phase_next         = phase;
    xkind_next         = xkind;
    polls_left_next    = polls_left;
    fifo_level_next    = fifo_level;
    read_index_next    = read_index;
    received_bits_next = received_bits;
    uid_next           = uid;
    do_end             = 1'b0;
    end_ok             = 1'b0;
    job.pre_wr         = 1'b0;
    job.pre_addr       = 6'h0D;
    job.pre_data       = 8'h00;
    job.pre_rd         = 1'b0;
    job.rd_addr        = 6'h0D;
    job.tail           = rfid_pkg::T_NONE;
    case (rfid_pkg::op_t'(operation))
      rfid_pkg::OP_INIT: begin
        job.tail   = rfid_pkg::T_INIT;
        phase_next = PH_INIT_TXC;
      end
      rfid_pkg::OP_SCAN: begin
        if (phase == PH_IDLE) begin
          job.tail   = rfid_pkg::T_SCAN;
          xkind_next = XK_REQ;
          phase_next = PH_BF_SET;
        end
      end
      rfid_pkg::OP_REPLY: begin
        case (phase)
          PH_INIT_TXC: begin
            job.pre_wr   = (b[1:0] == 2'b00);
            job.pre_addr = 6'h14;
            job.pre_data = b | 8'h03;
            job.tail     = rfid_pkg::T_INIT_DONE;
            phase_next   = PH_IDLE;
          end
          PH_BF_SET: begin
            job.pre_wr      = 1'b1;
            job.pre_data    = b | 8'h80;
            polls_left_next = (cfg.poll_limit != 7'd0) ? cfg.poll_limit : 7'd1;
            phase_next      = PH_WAIT_TICK;
          end
          PH_WAIT_IRQ: begin
            if (polls_left != 7'd0 && !b[0] && b[5:4] == 2'b00) begin
              phase_next = PH_WAIT_TICK;
            end else begin
              job.pre_rd = 1'b1;
              phase_next = PH_BF_CLEAR;
            end
          end
          PH_BF_CLEAR: begin
            job.pre_wr   = 1'b1;
            job.pre_data = b & 8'h7F;
            if (polls_left == 7'd0) begin
              do_end = 1'b1;
            end else begin
              job.pre_rd  = 1'b1;
              job.rd_addr = 6'h06;
              phase_next  = PH_ERR;
            end
          end
          PH_ERR: begin
            if ((b & cfg.error_mask) != 8'd0) begin
              do_end = 1'b1;
            end else begin
              job.pre_rd  = 1'b1;
              job.rd_addr = 6'h0A;
              phase_next  = PH_LEVEL;
            end
          end
          PH_LEVEL: begin
            fifo_level_next = b[6:0];
            job.pre_rd      = 1'b1;
            job.rd_addr     = 6'h0C;
            phase_next      = PH_CTRL;
          end
          PH_CTRL: begin
            if (lb != 3'd0) begin
              received_bits_next = ((10'(fifo_level) - 10'd1) << 3) + 10'(lb);
            end else begin
              received_bits_next = 10'(fifo_level) << 3;
            end
            read_index_next = 5'd0;
            job.pre_rd      = 1'b1;
            job.rd_addr     = 6'h09;
            phase_next      = PH_FIFO;
          end
          PH_FIFO: begin
            if ((xkind == XK_REQ || xkind == XK_ANTI) &&
                read_index < 5'(rfid_pkg::UID_BYTES)) begin
              case (read_index[2:0])
                3'd0:    uid_next[39:32] = b;
                3'd1:    uid_next[31:24] = b;
                3'd2:    uid_next[23:16] = b;
                3'd3:    uid_next[15:8]  = b;
                default: uid_next[7:0]   = b;
              endcase
            end
            read_index_next = ri_inc[4:0];
            if (ri_inc < {1'b0, read_count}) begin
              job.pre_rd  = 1'b1;
              job.rd_addr = 6'h09;
            end else begin
              do_end = 1'b1;
              end_ok = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (phase == PH_WAIT_TICK) begin
          job.pre_rd  = 1'b1;
          job.rd_addr = 6'h04;
          if (polls_left != 7'd0) polls_left_next = polls_left - 7'd1;
          phase_next  = PH_WAIT_IRQ;
        end
      end
    endcase
    if (do_end) begin
      phase_next = PH_IDLE;
      case (xkind)
        XK_REQ: begin
          if (end_ok && received_bits == 10'd16) begin
            job.tail   = rfid_pkg::T_ANTI;
            xkind_next = XK_ANTI;
            phase_next = PH_BF_SET;
          end else begin
            job.tail = rfid_pkg::T_NO_CARD;
          end
        end
        XK_ANTI: begin
          if (end_ok && uid_good) begin
            job.tail   = rfid_pkg::T_SEL;
            xkind_next = XK_SEL;
            phase_next = PH_BF_SET;
          end else begin
            job.tail = rfid_pkg::T_UID_FAIL;
          end
        end
        XK_SEL: begin
          if (end_ok) begin
            job.tail   = rfid_pkg::T_HALT;
            xkind_next = XK_HALT;
            phase_next = PH_BF_SET;
          end else begin
            job.tail = rfid_pkg::T_SEL_FAIL;
          end
        end
        default: job.tail = rfid_pkg::T_HALT_END;
      endcase
    end
    job.uid = uid_next;
  end

  assign job_valid = accept &&
                     (job.pre_wr || job.pre_rd || job.tail != rfid_pkg::T_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      xkind         <= XK_REQ;
      polls_left    <= 7'd0;
      fifo_level    <= 7'd0;
      read_index    <= 5'd0;
      received_bits <= 10'd0;
    end else if (accept) begin
      phase         <= phase_next;
      xkind         <= xkind_next;
      polls_left    <= polls_left_next;
      fifo_level    <= fifo_level_next;
      read_index    <= read_index_next;
      received_bits <= received_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) uid <= uid_next;
  end

endmodule

// ===== sv/rfid_job_queue.sv =====
// ----------------------------------------------------------------------------
// rfid_job_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module rfid_job_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rfid_pkg::job_t     push_job,
  input  logic               pop,
  output rfid_pkg::job_t     head,
  output rfid_pkg::q_stat_t  stat
);

  rfid_pkg::job_t mem [2];
  logic           wptr, rptr;
  logic [1:0]     count;

  assign head       = mem[rptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/rfid_back.sv =====
// ----------------------------------------------------------------------------
// rfid_back
// Expands each job into register accesses and done results.
// ----------------------------------------------------------------------------
module rfid_back (
  input  logic               clk,
  input  logic               rst,
  input  rfid_pkg::cfg_t     cfg,
  input  rfid_pkg::job_t     head,
  input  logic               has_job,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output rfid_pkg::res_t     res,
  output logic               res_last
);

  logic [4:0]       idx, cnt, k, tail_len;
  logic [4:0]       npre;
  logic             load;
  rfid_pkg::res_t   item;

  function automatic rfid_pkg::res_t mk(rfid_pkg::kind_t kd, logic [5:0] a,
                                        logic [7:0] d);
    rfid_pkg::res_t r;
    r.kind   = kd;
    r.addr   = a;
    r.data   = d;
    r.status = rfid_pkg::ST_SELECTED;
    r.uid    = 40'd0;
    return r;
  endfunction

  function automatic rfid_pkg::res_t xchg(logic [4:0] j, logic [4:0] len,
                                          logic [55:0] d);
    rfid_pkg::res_t r;
    logic [2:0]     di;
    di = 3'(j - 5'd4);
    if (j == 5'd0)           r = mk(rfid_pkg::K_WRITE, 6'h02, 8'hF7);
    else if (j == 5'd1)      r = mk(rfid_pkg::K_WRITE, 6'h04, 8'h7F);
    else if (j == 5'd2)      r = mk(rfid_pkg::K_WRITE, 6'h01, 8'h00);
    else if (j == 5'd3)      r = mk(rfid_pkg::K_WRITE, 6'h0A, 8'h80);
    else if (j < 5'd4 + len) r = mk(rfid_pkg::K_WRITE, 6'h09, d[55 - 8*di -: 8]);
    else if (j == 5'd4 + len) r = mk(rfid_pkg::K_WRITE, 6'h01, 8'h0C);
    else                     r = mk(rfid_pkg::K_READ, 6'h0D, 8'h00);
    return r;
  endfunction

  function automatic rfid_pkg::res_t done(rfid_pkg::status_t st, logic [39:0] u);
    rfid_pkg::res_t r;
    r        = mk(rfid_pkg::K_SCAN_DONE, 6'h00, 8'h00);
    r.status = st;
    r.uid    = u;
    return r;
  endfunction

  always_comb begin
    case (head.tail)
      rfid_pkg::T_INIT:      tail_len = 5'd9;
      rfid_pkg::T_INIT_DONE: tail_len = 5'd1;
      rfid_pkg::T_SCAN:      tail_len = 5'd8;
      rfid_pkg::T_ANTI:      tail_len = 5'd9;
      rfid_pkg::T_SEL:       tail_len = 5'd16;
      rfid_pkg::T_HALT:      tail_len = 5'd13;
      rfid_pkg::T_SEL_FAIL:  tail_len = 5'd3;
      rfid_pkg::T_HALT_END:  tail_len = 5'd3;
      rfid_pkg::T_NO_CARD:   tail_len = 5'd1;
      rfid_pkg::T_UID_FAIL:  tail_len = 5'd1;
      default:               tail_len = 5'd0;
    endcase
  end

  assign npre = {4'd0, head.pre_wr} + {4'd0, head.pre_rd};
  assign cnt  = npre + tail_len;
  assign k    = idx - npre;

  always_comb begin
    item = mk(rfid_pkg::K_WRITE, 6'h00, 8'h00);
    if (head.pre_wr && idx == 5'd0) begin
      item = mk(rfid_pkg::K_WRITE, head.pre_addr, head.pre_data);
    end else if (head.pre_rd && idx == {4'd0, head.pre_wr}) begin
      item = mk(rfid_pkg::K_READ, head.rd_addr, 8'h00);
    end else begin
      case (head.tail)
        rfid_pkg::T_INIT: begin
          case (k)
            5'd0:    item = mk(rfid_pkg::K_WRITE, 6'h01, 8'h0F);
            5'd1:    item = mk(rfid_pkg::K_WRITE, 6'h2A, cfg.timer_mode);
            5'd2:    item = mk(rfid_pkg::K_WRITE, 6'h2B, cfg.timer_prescaler);
            5'd3:    item = mk(rfid_pkg::K_WRITE, 6'h2C, cfg.timer_reload[7:0]);
            5'd4:    item = mk(rfid_pkg::K_WRITE, 6'h2D, cfg.timer_reload[15:8]);
            5'd5:    item = mk(rfid_pkg::K_WRITE, 6'h15, 8'h40);
            5'd6:    item = mk(rfid_pkg::K_WRITE, 6'h11, cfg.mode_setting);
            5'd7:    item = mk(rfid_pkg::K_WRITE, 6'h26, cfg.rf_gain_setting);
            default: item = mk(rfid_pkg::K_READ, 6'h14, 8'h00);
          endcase
        end
        rfid_pkg::T_INIT_DONE: item = mk(rfid_pkg::K_INIT_DONE, 6'h00, 8'h00);
        rfid_pkg::T_SCAN: begin
          if (k == 5'd0) item = mk(rfid_pkg::K_WRITE, 6'h0D, 8'h07);
          else item = xchg(k - 5'd1, 5'd1, {cfg.request_code, 48'd0});
        end
        rfid_pkg::T_ANTI: begin
          if (k == 5'd0) item = mk(rfid_pkg::K_WRITE, 6'h0D, 8'h00);
          else item = xchg(k - 5'd1, 5'd2, {8'h93, 8'h20, 40'd0});
        end
        rfid_pkg::T_SEL: begin
          case (k)
            5'd0:    item = mk(rfid_pkg::K_WRITE, 6'h12, 8'h80);
            5'd1:    item = mk(rfid_pkg::K_WRITE, 6'h13, 8'h80);
            5'd2:    item = mk(rfid_pkg::K_WRITE, 6'h0D, 8'h00);
            default: item = xchg(k - 5'd3, 5'd7, {8'h93, 8'h70, head.uid});
          endcase
        end
        rfid_pkg::T_HALT: begin
          case (k)
            5'd0:    item = mk(rfid_pkg::K_WRITE, 6'h12, 8'h00);
            5'd1:    item = mk(rfid_pkg::K_WRITE, 6'h13, 8'h00);
            5'd2:    item = mk(rfid_pkg::K_WRITE, 6'h12, 8'h80);
            5'd3:    item = mk(rfid_pkg::K_WRITE, 6'h13, 8'h80);
            5'd4:    item = mk(rfid_pkg::K_WRITE, 6'h0D, 8'h00);
            default: item = xchg(k - 5'd5, 5'd2, {8'h50, 8'h00, 40'd0});
          endcase
        end
        rfid_pkg::T_SEL_FAIL, rfid_pkg::T_HALT_END: begin
          case (k)
            5'd0:    item = mk(rfid_pkg::K_WRITE, 6'h12, 8'h00);
            5'd1:    item = mk(rfid_pkg::K_WRITE, 6'h13, 8'h00);
            default: item = done((head.tail == rfid_pkg::T_SEL_FAIL) ?
                                 rfid_pkg::ST_SEL_FAIL : rfid_pkg::ST_SELECTED,
                                 head.uid);
          endcase
        end
        rfid_pkg::T_NO_CARD:  item = done(rfid_pkg::ST_NO_CARD, 40'd0);
        rfid_pkg::T_UID_FAIL: item = done(rfid_pkg::ST_UID_FAIL, 40'd0);
        default: ;
      endcase
    end
  end

  assign load = has_job && (!m_tvalid || m_tready);
  assign pop  = load && (idx == cnt - 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 5'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= pop ? 5'd0 : idx + 5'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res      <= item;
      res_last <= pop;
    end
  end

endmodule

// ===== sv/rfid_uid_read_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// rfid_uid_read_sequencer_core
// Card UID read sequencer: request, anticollision, select and halt.
// ----------------------------------------------------------------------------
// Results: jobs pass the job queue and the output register; one result per
// cycle from the job expander while m_tready allows (up to 16 per request).
// Throughput: one request per cycle while the two-entry job queue has room.
// Reset: synchronous, active high; config returns to defaults, phase idle.
`include "rfid_uid_read_sequencer_core_defines.svh"
module rfid_uid_read_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // read_byte
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // reg_addr, write_data, scan_status, card_uid
  output logic [1:0]  m_tuser,   // access_kind
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rfid_pkg::cfg_t    cfg;
  rfid_pkg::job_t    job, head;
  rfid_pkg::q_stat_t qstat;
  rfid_pkg::res_t    res;
  logic              accept, job_valid, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_code    <= 8'd38;
      cfg.poll_limit      <= 7'd80;
      cfg.timer_mode      <= 8'd141;
      cfg.timer_prescaler <= 8'd62;
      cfg.timer_reload    <= 16'd30;
      cfg.mode_setting    <= 8'd61;
      cfg.rf_gain_setting <= 8'd96;
      cfg.error_mask      <= 8'd27;
    end else if (cfg_we) begin
      case (rfid_pkg::cfg_idx_t'(cfg_index))
        rfid_pkg::CFG_REQUEST:  cfg.request_code    <= cfg_data[7:0];
        rfid_pkg::CFG_POLL:     cfg.poll_limit      <= cfg_data[6:0];
        rfid_pkg::CFG_TMODE:    cfg.timer_mode      <= cfg_data[7:0];
        rfid_pkg::CFG_TPRESC:   cfg.timer_prescaler <= cfg_data[7:0];
        rfid_pkg::CFG_TRELOAD:  cfg.timer_reload    <= cfg_data;
        rfid_pkg::CFG_MODE:     cfg.mode_setting    <= cfg_data[7:0];
        rfid_pkg::CFG_GAIN:     cfg.rf_gain_setting <= cfg_data[7:0];
        default:                cfg.error_mask      <= cfg_data[7:0];
      endcase
    end
  end

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;

  rfid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_tuser),
    .read_byte (s_tdata),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job)
  );

  rfid_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  rfid_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .has_job  (!qstat.empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res),
    .res_last (m_tlast)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {res.uid, res.status, res.data, res.addr};

  `RUS_ASSERT(a_done_last, clk, rst, m_tvalid && (m_tuser == rfid_pkg::K_INIT_DONE || m_tuser == rfid_pkg::K_SCAN_DONE) |-> m_tlast, "done result not last of run")
  `RUS_ASSERT(a_fail_no_uid, clk, rst, m_tvalid && m_tuser == rfid_pkg::K_SCAN_DONE && m_tdata[15] |-> m_tdata[55:16] == 40'd0, "failed scan carries a uid")
  `RUS_ASSERT(a_read_no_data, clk, rst, m_tvalid && m_tuser == rfid_pkg::K_READ |-> m_tdata[13:6] == 8'd0 && m_tdata[55:14] == 42'd0, "read request with payload")
  `RUS_ASSERT(a_no_push_full, clk, rst, qstat.full |-> !accept, "request taken with full queue")

endmodule
